/* rtl/mbcm_pkg.sv */
// Shared types and constants for the motion box change marker.
package mbcm_pkg;

	localparam int POS_W   = 11;
	localparam int CNT_W   = 11;
	localparam int PIX_W   = 8;
	localparam int EPOCH_W = 24;
	localparam int IDX_W   = 2;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	localparam logic [POS_W-1:0] ROWS_RST       = 11'd1080;
	localparam logic [POS_W-1:0] COLS_RST       = 11'd1920;
	localparam logic [PIX_W-1:0] BRIGHT_THR_RST = 8'd200;
	localparam logic [CNT_W-1:0] MOTION_THR_RST = 11'd10;

	typedef enum logic [IDX_W-1:0] {
		REG_FRAME_ROWS = 2'd0,
		REG_FRAME_COLS = 2'd1,
		REG_BRIGHT_THR = 2'd2,
		REG_MOTION_THR = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [POS_W-1:0] frame_rows;
		logic [POS_W-1:0] frame_cols;
		logic [PIX_W-1:0] bright_thr;
		logic [CNT_W-1:0] motion_thr;
	} cfg_t;

	// Classified pixel handed from the front to the back
	typedef struct packed {
		logic [PIX_W-1:0]   ch2;
		logic [PIX_W-1:0]   ch1;
		logic [PIX_W-1:0]   ch0;
		logic               inc;
		logic               box_end;
		logic               last;
		logic               in_store;
		logic [EPOCH_W-1:0] epoch;
	} pix_item_t;

	// One box entry: sticky mark, frame tag, previous and present counts
	typedef struct packed {
		logic               mark;
		logic [EPOCH_W-1:0] tag;
		logic [CNT_W-1:0]   prev;
		logic [CNT_W-1:0]   cur;
	} box_entry_t;

endpackage

/* rtl/mbcm_front.sv */
// Front end: raster position tracking, pixel classification and box number.
module mbcm_front #(
	parameter int BOX_SIZE  = 32,
	parameter int MAX_BOXES = 2048,
	parameter int AW        = 11
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mbcm_pkg::cfg_t      cfg,
	input  logic                clr_busy,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [31:0]         s_tdata,   // mask_level, cam_ch0, cam_ch1, cam_ch2
	output logic                q_valid,
	input  logic                q_ready,
	output mbcm_pkg::pix_item_t q_item,
	output logic [AW-1:0]       q_addr
);
	import mbcm_pkg::*;

	localparam int OFF_W    = $clog2(BOX_SIZE);
	localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(BOX_SIZE - 1);
	localparam int RECIP_SH = 24;
	localparam int RECIP_W  = 25;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SH) + BOX_SIZE - 1) / BOX_SIZE);
	localparam int PROD_W   = POS_W + RECIP_W;
	localparam int BOX_W    = 2 * POS_W + 1;

	logic [PROD_W-1:0]  bpr_prod;
	logic [POS_W-1:0]   bpr_q;

	logic [POS_W-1:0]   col_q, row_q, col_box_q, row_box_q;
	logic [OFF_W-1:0]   col_off_q, row_off_q;
	logic [EPOCH_W-1:0] epoch_q;

	logic               accept;
	logic [POS_W-1:0]   cols, rows;
	logic               col_wrap, row_wrap, frame_start;
	logic [EPOCH_W-1:0] epoch_next;

	logic               s1_valid_q;
	pix_item_t          item_s1;
	logic [POS_W-1:0]   col_box_s1, row_box_s1;

	logic [2*POS_W-1:0] row_prod;
	logic [BOX_W-1:0]   box_num;
	logic               in_store;

	// Boxes per row from the column count, by reciprocal multiply
	assign bpr_prod = PROD_W'(cfg.frame_cols) * PROD_W'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpr_q <= '0;
		end else begin
			bpr_q <= bpr_prod[RECIP_SH +: POS_W];
		end
	end

	// Frame geometry at the current position
	assign cols        = (cfg.frame_cols == '0) ? POS_W'(1) : cfg.frame_cols;
	assign rows        = (cfg.frame_rows == '0) ? POS_W'(1) : cfg.frame_rows;
	assign col_wrap    = ({1'b0, col_q} + (POS_W+1)'(1)) >= {1'b0, cols};
	assign row_wrap    = ({1'b0, row_q} + (POS_W+1)'(1)) >= {1'b0, rows};
	assign frame_start = (col_q == '0) && (row_q == '0);
	assign epoch_next  = frame_start ? epoch_q + EPOCH_W'(1) : epoch_q;

	assign s_tready = !clr_busy && (!s1_valid_q || q_ready);
	assign accept   = s_tvalid && s_tready;

	// Advance the raster position and the frame epoch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			col_off_q <= '0;
			row_off_q <= '0;
			col_box_q <= '0;
			row_box_q <= '0;
			epoch_q   <= '0;
		end else if (accept) begin
			epoch_q <= epoch_next;
			if (col_wrap) begin
				col_q     <= '0;
				col_off_q <= '0;
				col_box_q <= '0;
				if (row_wrap) begin
					row_q     <= '0;
					row_off_q <= '0;
					row_box_q <= '0;
				end else begin
					row_q <= row_q + POS_W'(1);
					if (row_off_q == OFF_LAST) begin
						row_off_q <= '0;
						row_box_q <= row_box_q + POS_W'(1);
					end else begin
						row_off_q <= row_off_q + OFF_W'(1);
					end
				end
			end else begin
				col_q <= col_q + POS_W'(1);
				if (col_off_q == OFF_LAST) begin
					col_off_q <= '0;
					col_box_q <= col_box_q + POS_W'(1);
				end else begin
					col_off_q <= col_off_q + OFF_W'(1);
				end
			end
		end
	end

	// Capture the classified pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (q_ready) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.ch0      <= s_tdata[15:8];
			item_s1.ch1      <= s_tdata[23:16];
			item_s1.ch2      <= s_tdata[31:24];
			item_s1.inc      <= s_tdata[7:0] > cfg.bright_thr;
			item_s1.box_end  <= (col_off_q == OFF_LAST) && (row_off_q == OFF_LAST);
			item_s1.last     <= col_wrap && row_wrap;
			item_s1.in_store <= 1'b0;
			item_s1.epoch    <= epoch_next;
			col_box_s1       <= col_box_q;
			row_box_s1       <= row_box_q;
		end
	end

	// Box number and store range check
	assign row_prod = (2*POS_W)'(row_box_s1) * (2*POS_W)'(bpr_q);
	assign box_num  = BOX_W'(row_prod) + BOX_W'(col_box_s1);
	assign in_store = box_num < BOX_W'(MAX_BOXES);

	always_comb begin
		q_item          = item_s1;
		q_item.in_store = in_store;
	end

	assign q_valid = s1_valid_q;
	assign q_addr  = box_num[AW-1:0];

endmodule

/* rtl/mbcm_queue.sv */
// Short request queue between the front and the back.
module mbcm_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);
	localparam int PTR_W = $clog2(DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [PTR_W:0]   cnt_q;
	logic             push, pop;

	assign push_ready = cnt_q != (PTR_W+1)'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (PTR_W+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (PTR_W+1)'(1);
			end
		end
	end

	// Store the request
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

/* rtl/mbcm_back.sv */
// Back end: box store read-modify-write, mark update and output register.
module mbcm_back #(
	parameter int MAX_BOXES = 2048,
	parameter int AW        = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [mbcm_pkg::CNT_W-1:0]    motion_thr,
	input  logic                          q_valid,
	output logic                          q_ready,
	input  mbcm_pkg::pix_item_t           q_item,
	input  logic [AW-1:0]                 q_addr,
	output logic                          clr_busy,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [23:0]                   m_tdata,  // out_ch0, out_ch1, out_ch2
	output logic [0:0]                    m_tuser,  // box_marked
	output logic                          m_tlast   // frame_end
);
	import mbcm_pkg::*;

	localparam logic [AW-1:0] CLR_LAST = AW'(MAX_BOXES - 1);

	box_entry_t         mem [MAX_BOXES];

	logic               clr_busy_q;
	logic [AW-1:0]      clr_idx_q;

	logic               pop;
	logic               b1_valid_q, b1_adv;
	pix_item_t          item_s1;
	logic [AW-1:0]      addr_s1;
	logic               fwd_s1;
	box_entry_t         rd_word_s1;
	box_entry_t         wr_word_q;

	box_entry_t         word;
	logic [CNT_W-1:0]   pres, prev, new_cur, diff;
	logic [EPOCH_W-1:0] epoch_prev;
	logic               moved;
	logic               wr_en;
	box_entry_t         wr_word;
	logic               marked;

	logic               m_valid_q;
	logic [23:0]        m_data_q;
	logic               m_user_q, m_last_q;

	assign clr_busy = clr_busy_q;

	// Sweep the store to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_idx_q == CLR_LAST) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + AW'(1);
			end
		end
	end

	assign b1_adv  = b1_valid_q && (!m_valid_q || m_tready);
	assign pop     = q_valid && !clr_busy_q && (!b1_valid_q || b1_adv);
	assign q_ready = pop;

	// Take the next request and read its box entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b1_valid_q <= 1'b0;
		end else if (pop) begin
			b1_valid_q <= 1'b1;
		end else if (b1_adv) begin
			b1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1    <= q_item;
			addr_s1    <= q_addr;
			rd_word_s1 <= mem[q_addr];
			fwd_s1     <= b1_adv && item_s1.in_store && (addr_s1 == q_addr);
		end
	end

	// Resolve the entry against the frame epoch and update it
	assign word       = fwd_s1 ? wr_word_q : rd_word_s1;
	assign epoch_prev = item_s1.epoch - EPOCH_W'(1);

	always_comb begin
		if (word.tag == item_s1.epoch) begin
			pres = word.cur;
			prev = word.prev;
		end else if (word.tag == epoch_prev) begin
			pres = '0;
			prev = word.cur;
		end else begin
			pres = '0;
			prev = '0;
		end
	end

	assign new_cur = (item_s1.inc && pres != COUNT_MAX) ? pres + CNT_W'(1) : pres;
	assign diff    = (new_cur > prev) ? new_cur - prev : prev - new_cur;
	assign moved   = item_s1.box_end && (diff > motion_thr);
	assign marked  = item_s1.in_store && word.mark;

	always_comb begin
		wr_word.mark = word.mark | moved;
		wr_word.tag  = item_s1.epoch;
		wr_word.prev = prev;
		wr_word.cur  = new_cur;
	end

	assign wr_en = b1_adv && item_s1.in_store;

	// Write the store: clearing sweep or entry update
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_idx_q] <= '0;
		end else if (wr_en) begin
			mem[addr_s1] <= wr_word;
		end
	end

	// Hold the last written entry for a back-to-back hit
	always_ff @(posedge clk) begin
		if (wr_en) begin
			wr_word_q <= wr_word;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (b1_adv) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (b1_adv) begin
			if (marked) begin
				m_data_q <= {item_s1.ch0, 8'd0, 8'd0};
			end else begin
				m_data_q <= {item_s1.ch2, item_s1.ch1, item_s1.ch0};
			end
			m_user_q <= marked;
			m_last_q <= item_s1.last;
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = m_data_q;
	assign m_tuser[0] = m_user_q;
	assign m_tlast    = m_last_q;

	a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !pop)
		else $error("request taken during store clear");

	a_b1_empty_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !b1_valid_q)
		else $error("update stage busy during store clear");

	a_fwd_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && b1_adv && item_s1.in_store && addr_s1 == q_addr) |=> fwd_s1)
		else $error("missed forward of a just-written box entry");

	a_write_only_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (b1_valid_q && !clr_busy_q))
		else $error("store written without a live update");

endmodule

/* rtl/motion_box_change_marker_core.sv */
// Top level of the motion box change marker: configuration registers and assembly.
// Path: front-end register, request queue, box-store read register, then output register.
// Throughput: one pixel per clock unless output back-pressure or the store sweep holds it.
// Reset: asynchronous, active low; configuration returns to 1080x1920, thresholds 200 and 10.
// After reset the box store is swept to zero, one entry per cycle, MAX_BOXES entries in all
// (2048 by default); s_tready stays low during the sweep, configuration writes are taken.
module motion_box_change_marker_core #(
	parameter int BOX_SIZE  = 32,
	parameter int MAX_BOXES = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // mask_level, cam_ch0, cam_ch1, cam_ch2
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // out_ch0, out_ch1, out_ch2
	output logic [0:0]  m_tuser,   // box_marked
	output logic        m_tlast    // frame_end
);
	import mbcm_pkg::*;

	localparam int AW = $clog2(MAX_BOXES);
	localparam int QW = $bits(pix_item_t) + AW;

	cfg_t          cfg_q;
	logic          clr_busy;

	logic          fq_valid, fq_ready;
	pix_item_t     fq_item;
	logic [AW-1:0] fq_addr;

	logic          bq_valid, bq_ready;
	logic [QW-1:0] bq_data;
	pix_item_t     bq_item;
	logic [AW-1:0] bq_addr;

	assign cfg_ready = 1'b1;

	// Configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_rows <= ROWS_RST;
			cfg_q.frame_cols <= COLS_RST;
			cfg_q.bright_thr <= BRIGHT_THR_RST;
			cfg_q.motion_thr <= MOTION_THR_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_FRAME_ROWS: cfg_q.frame_rows <= cfg_data;
				REG_FRAME_COLS: cfg_q.frame_cols <= cfg_data;
				REG_BRIGHT_THR: cfg_q.bright_thr <= cfg_data[PIX_W-1:0];
				REG_MOTION_THR: cfg_q.motion_thr <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	mbcm_front #(
		.BOX_SIZE  (BOX_SIZE),
		.MAX_BOXES (MAX_BOXES),
		.AW        (AW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.clr_busy (clr_busy),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_valid  (fq_valid),
		.q_ready  (fq_ready),
		.q_item   (fq_item),
		.q_addr   (fq_addr)
	);

	mbcm_queue #(
		.W     (QW),
		.DEPTH (4)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  ({fq_addr, fq_item}),
		.pop_valid  (bq_valid),
		.pop_ready  (bq_ready),
		.pop_data   (bq_data)
	);

	assign bq_item = pix_item_t'(bq_data[$bits(pix_item_t)-1:0]);
	assign bq_addr = bq_data[QW-1 -: AW];

	mbcm_back #(
		.MAX_BOXES (MAX_BOXES),
		.AW        (AW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.motion_thr (cfg_q.motion_thr),
		.q_valid    (bq_valid),
		.q_ready    (bq_ready),
		.q_item     (bq_item),
		.q_addr     (bq_addr),
		.clr_busy   (clr_busy),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

/* bench/mbcm_checker.sv */
// Scoreboard for the motion box change marker: predicts every output pixel and compares it.
module mbcm_checker #(
	parameter int BOX_SIZE  = 32,
	parameter int MAX_BOXES = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // mask_level, cam_ch0, cam_ch1, cam_ch2
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // out_ch0, out_ch1, out_ch2
	input  logic [0:0]  m_tuser,   // box_marked
	input  logic        m_tlast,   // frame_end
	output int          pending,
	output int          fail_count
);
	import mbcm_pkg::*;

	typedef struct packed {
		logic [PIX_W-1:0] ch0;
		logic [PIX_W-1:0] ch1;
		logic [PIX_W-1:0] ch2;
		logic             marked;
		logic             frame_end;
	} tinted_pixel_t;

	// Predictor state: per-box counts of this and the last frame, sticky marks, raster position
	logic [CNT_W-1:0] hits_now   [MAX_BOXES];
	logic [CNT_W-1:0] hits_prior [MAX_BOXES];
	logic             box_flag   [MAX_BOXES];
	logic [POS_W-1:0] row_pos;
	logic [POS_W-1:0] col_pos;
	cfg_t             cfg;

	tinted_pixel_t    expected_pixels [$];
	tinted_pixel_t    want;
	int               errors;

	// Return the predictor to its power-up state
	function automatic void clear_model();
		for (int i = 0; i < MAX_BOXES; i++) begin
			hits_now[i]   = '0;
			hits_prior[i] = '0;
			box_flag[i]   = 1'b0;
		end
		row_pos        = '0;
		col_pos        = '0;
		cfg.frame_rows = ROWS_RST;
		cfg.frame_cols = COLS_RST;
		cfg.bright_thr = BRIGHT_THR_RST;
		cfg.motion_thr = MOTION_THR_RST;
	endfunction

	// Classify one pixel, update the box store and advance the raster position
	function automatic tinted_pixel_t tint_pixel(input logic [31:0] word);
		logic [PIX_W-1:0] mask;
		logic [PIX_W-1:0] c0;
		logic [PIX_W-1:0] c1;
		logic [PIX_W-1:0] c2;
		int               rows;
		int               cols;
		int               row;
		int               col;
		int               box;
		int               diff;
		logic             marked;
		tinted_pixel_t    px;
		mask   = word[7:0];
		c0     = word[15:8];
		c1     = word[23:16];
		c2     = word[31:24];
		rows   = (cfg.frame_rows == '0) ? 1 : int'(cfg.frame_rows);
		cols   = (cfg.frame_cols == '0) ? 1 : int'(cfg.frame_cols);
		row    = int'(row_pos);
		col    = int'(col_pos);
		marked = 1'b0;

		// frame start: retire this frame's counts before the pixel is used
		if (row == 0 && col == 0) begin
			for (int i = 0; i < MAX_BOXES; i++) begin
				hits_prior[i] = hits_now[i];
				hits_now[i]   = '0;
			end
		end

		box = col / BOX_SIZE + (row / BOX_SIZE) * (int'(cfg.frame_cols) / BOX_SIZE);
		if (box < MAX_BOXES) begin
			marked = box_flag[box];
			if (mask > cfg.bright_thr && hits_now[box] != COUNT_MAX)
				hits_now[box]++;
			// bottom-right pixel of the box: compare against the last frame
			if (col % BOX_SIZE == BOX_SIZE - 1 && row % BOX_SIZE == BOX_SIZE - 1) begin
				diff = int'(hits_now[box]) - int'(hits_prior[box]);
				if (diff < 0)
					diff = -diff;
				if (diff > int'(cfg.motion_thr))
					box_flag[box] = 1'b1;
			end
		end

		px.ch0       = marked ? '0 : c0;
		px.ch1       = marked ? '0 : c1;
		px.ch2       = marked ? c0 : c2;
		px.marked    = marked;
		px.frame_end = (col + 1 >= cols) && (row + 1 >= rows);

		// advance, wrapping a position left outside the frame
		col++;
		if (col >= cols) begin
			col = 0;
			row++;
			if (row >= rows)
				row = 0;
		end
		col_pos = col[POS_W-1:0];
		row_pos = row[POS_W-1:0];
		return px;
	endfunction

	// Report one field that differs from its prediction
	task automatic compare_field(input string name, input logic [7:0] want_v,
			input logic [7:0] got_v);
		if (got_v !== want_v) begin
			errors++;
			$display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
		end
	endtask

	// Watch all three channels and both flags; outputs first, so a same-edge input cannot match it
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_model();
			expected_pixels.delete();
			errors = 0;
			pending    <= 0;
			fail_count <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_pixels.size() == 0) begin
					errors++;
					$display("%0t: output pixel expected none actual %h/%b/%b", $time,
						m_tdata, m_tuser, m_tlast);
				end else begin
					want = expected_pixels.pop_front();
					compare_field("out_ch0", want.ch0, m_tdata[7:0]);
					compare_field("out_ch1", want.ch1, m_tdata[15:8]);
					compare_field("out_ch2", want.ch2, m_tdata[23:16]);
					compare_field("box_marked", {7'd0, want.marked}, {7'd0, m_tuser[0]});
					compare_field("frame_end", {7'd0, want.frame_end}, {7'd0, m_tlast});
				end
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FRAME_ROWS: cfg.frame_rows = cfg_data;
					REG_FRAME_COLS: cfg.frame_cols = cfg_data;
					REG_BRIGHT_THR: cfg.bright_thr = cfg_data[PIX_W-1:0];
					REG_MOTION_THR: cfg.motion_thr = cfg_data;
					default: ;
				endcase
			end

			if (s_tvalid && s_tready)
				expected_pixels.push_back(tint_pixel(s_tdata));

			pending    <= expected_pixels.size();
			fail_count <= errors;
		end
	end

endmodule

/* bench/motion_box_change_marker_core_tb.sv */
// Stimulus and verdict for the motion box change marker core.
module motion_box_change_marker_core_tb;
	import mbcm_pkg::*;

	localparam int BOX_SIZE      = 32;
	localparam int MAX_BOXES     = 2048;
	localparam int TOTAL_PIXELS  = 1050;
	localparam int BAND_MAX      = 320;
	localparam int IDLE_PCT      = 29;
	localparam int STALL_CYCLES  = 400;
	localparam int CYCLE_LIMIT   = 400000;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [10:0] cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata   = '0;   // mask_level, cam_ch0, cam_ch1, cam_ch2
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;          // out_ch0, out_ch1, out_ch2
	logic [0:0]  m_tuser;          // box_marked
	logic        m_tlast;          // frame_end

	int pending;
	int fail_count;
	int pixels_sent  = 0;
	int cycle_count  = 0;
	int hold_left    = 0;
	bit pressure_req = 1'b0;

	motion_box_change_marker_core #(
		.BOX_SIZE  (BOX_SIZE),
		.MAX_BOXES (MAX_BOXES)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	mbcm_checker #(
		.BOX_SIZE  (BOX_SIZE),
		.MAX_BOXES (MAX_BOXES)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.pending    (pending),
		.fail_count (fail_count)
	);

	always #1 clk = ~clk;

	// Abort a run that hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Stretch with no idling on either side
	function automatic bit calm_now();
		return (pixels_sent >= 700) && (pixels_sent < 1100);
	endfunction

	// Output side: random back-pressure, plus one long hold when requested
	always @(posedge clk) begin
		if (pressure_req) begin
			pressure_req = 1'b0;
			hold_left    = STALL_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= calm_now() || ($urandom_range(99, 0) >= IDLE_PCT);
		end
	end

	// Offer one register request and hold it until taken
	task automatic write_reg(input cfg_reg_t idx, input logic [10:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Write all four registers; junk rides in the unused bits of the brightness write
	task automatic program_regs(input int rows, input int cols, input int bright,
			input int motion);
		write_reg(REG_FRAME_ROWS, 11'(rows));
		write_reg(REG_FRAME_COLS, 11'(cols));
		write_reg(REG_BRIGHT_THR, {3'($urandom), 8'(bright)});
		write_reg(REG_MOTION_THR, 11'(motion));
		cfg_valid <= 1'b0;
	endtask

	// Random pixel with mask level no lower than mask_lo
	function automatic logic [31:0] pixel_word(input int mask_lo);
		return {8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(255, mask_lo))};
	endfunction

	// Offer one pixel request after a random gap and hold it until taken
	task automatic send_pixel(input logic [31:0] word);
		while (!calm_now() && $urandom_range(99, 0) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		do @(posedge clk); while (!s_tready);
		pixels_sent++;
	endtask

	// Drop valid and wait until every predicted pixel has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic run_phase(input int rows, input int cols, input int bright,
			input int motion, input int count, input int mask_lo);
		program_regs(rows, cols, bright, motion);
		repeat (count) send_pixel(pixel_word(mask_lo));
		drain();
	endtask

	initial begin
		int mode;
		int j;
		int k;
		int b;
		int m;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: channel extremes and the brightness boundary at reset settings
		program_regs(ROWS_RST, COLS_RST, BRIGHT_THR_RST, MOTION_THR_RST);
		send_pixel(32'h0000_0000);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h55AA_33C8);
		send_pixel(32'hAA55_CCC9);
		send_pixel(32'h0102_03FF);
		drain();
		// tiny frame entered from a column beyond it: wrap, frame end, frame start
		program_regs(2, 3, 0, 0);
		repeat (7) send_pixel(pixel_word(0));
		drain();
		// zero frame size with threshold extremes
		program_regs(0, 0, 255, 2047);
		repeat (3) send_pixel(pixel_word(0));
		drain();
		program_regs(1, 2047, 0, 1024);
		repeat (3) send_pixel(pixel_word(0));
		drain();

		// hold the output off while the input keeps offering
		pressure_req = 1'b1;
		run_phase($urandom_range(1, 2047), $urandom_range(1, 2047), $urandom_range(0, 255),
			$urandom_range(0, 2047), 200, 0);

		while (pixels_sent < TOTAL_PIXELS) begin
			mode = $urandom_range(0, 9);
			b    = $urandom_range(0, 255);
			m    = ($urandom_range(0, 7) == 0) ? $urandom_range(1024, 2047)
				: $urandom_range(0, 40);
			if (mode < 4 && pixels_sent + BAND_MAX <= TOTAL_PIXELS) begin
				// band: home, drop to a box's last row on one-pixel rows, sweep k boxes
				j = $urandom_range(0, 3);
				k = $urandom_range(1, 6);
				run_phase(1, 1, b, m, 1, 0);
				run_phase(2047, $urandom_range(0, 1), b, m, 31 + 32 * j, 0);
				run_phase(32 * (j + 1), ($urandom_range(0, 1) == 0) ? 32 * k
					: 32 * k + $urandom_range(1, 31), b, m, 32 * k, 0);
			end else if (mode < 7) begin
				run_phase($urandom_range(0, 5), $urandom_range(0, 6), b, m,
					$urandom_range(5, 40), 0);
			end else begin
				run_phase($urandom_range(0, 2047), $urandom_range(0, 2047), b,
					$urandom_range(0, 2047), $urandom_range(20, 80), 0);
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
